[rtl/core/focvm_pkg.sv]
package focvm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int DUTY_MAX = 255;
    localparam int K_BITS = $clog2(SINE_TABLE_DEPTH);

    localparam int SIN_A = 102944;
    localparam int SIN_B = 42048;
    localparam int SIN_C = 4640;
    localparam int SQRT3_HALF_Q16 = 56756;

    // register indexes
    localparam logic [2:0] REG_BUS_VOLTAGE = 3'd0;
    localparam logic [2:0] REG_POLE_PAIRS = 3'd1;
    localparam logic [2:0] REG_REVERSE_DIR = 3'd2;
    localparam logic [2:0] REG_ZERO_OFFSET = 3'd3;
    localparam logic [2:0] REG_PARK_MODE = 3'd4;

    typedef struct packed {
        logic [15:0] bus_voltage;
        logic [5:0]  pole_pairs;
        logic        reverse_direction;
        logic [15:0] zero_offset;
        logic        park_mode;
    } cfg_t;

    // sin(pi/2 * x), x in 0..65536, result 0..65536
    function automatic logic [16:0] quarter_sine(input logic [16:0] x);
        logic [33:0] xx;
        logic [16:0] x2;
        logic [29:0] t1;
        logic [16:0] t;
        logic [33:0] t2;
        logic [17:0] u;
        logic [34:0] r;
        xx = 34'(x) * 34'(x);
        x2 = xx[32:16];
        t1 = 30'(SIN_C) * 30'(x2);
        t = 17'(SIN_B) - 17'(t1[29:16]);
        t2 = 34'(t) * 34'(x2);
        u = 18'(SIN_A) - 18'(t2[33:16]);
        r = 35'(u) * 35'(x);
        return r[32:16];
    endfunction

    // signed sine of a 16 bit turn phase
    function automatic logic signed [17:0] phase_sine(input logic [15:0] p);
        logic [16:0] x;
        logic [16:0] v;
        x = {1'b0, p[13:0], 2'b00};
        v = p[14] ? quarter_sine(17'd65536 - x) : quarter_sine(x);
        return p[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // sine table over the quantized angle steps
    function automatic logic signed [17:0] sine_entry(input logic [K_BITS-1:0] k);
        logic [15:0] ph;
        ph = 16'((32'(k) << 16) / SINE_TABLE_DEPTH);
        return phase_sine(ph);
    endfunction

endpackage

[rtl/core/focvm_duty.sv]
module focvm_duty (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [50:0] phase_v,
    input  logic [15:0]        bus,
    output logic [7:0]         duty
);
    import focvm_pkg::*;

    logic [49:0] vmax;
    logic [41:0] clamped;
    logic [49:0] full_reg;
    logic [15:0] bus_reg;
    logic [24:0] rem_hi;
    logic [3:0]  q_hi;
    logic [24:0] rem_mid_reg;
    logic [3:0]  q_hi_reg;
    logic [15:0] bus_mid_reg;
    logic [24:0] rem_lo;
    logic [3:0]  q_lo;

    // clamp to 0..2*bus*2^32 and keep the value above bit 8
    always_comb begin
        vmax = {1'b0, bus, 33'd0};
        if (phase_v < 0) clamped = '0;
        else if (phase_v[49:0] > vmax) clamped = vmax[49:8];
        else clamped = phase_v[49:8];
    end

    // scale by DUTY_MAX; floor(x / (bus << 25)) = floor((x >> 25) / bus)
    always_ff @(posedge aclk) begin
        if (en) begin
            full_reg <= 50'(clamped) * 50'(DUTY_MAX);
            bus_reg <= bus;
        end
    end

    // quotient is at most 255: upper four bits of the restoring divide
    always_comb begin
        rem_hi = full_reg[49:25];
        q_hi = '0;
        for (int i = 3; i >= 0; i--) begin
            if (rem_hi >= (25'(bus_reg) << (i + 4))) begin
                rem_hi = rem_hi - (25'(bus_reg) << (i + 4));
                q_hi[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_mid_reg <= rem_hi;
            q_hi_reg <= q_hi;
            bus_mid_reg <= bus_reg;
        end
    end

    // lower four quotient bits
    always_comb begin
        rem_lo = rem_mid_reg;
        q_lo = '0;
        for (int i = 3; i >= 0; i--) begin
            if (rem_lo >= (25'(bus_mid_reg) << i)) begin
                rem_lo = rem_lo - (25'(bus_mid_reg) << i);
                q_lo[i] = 1'b1;
            end
        end
    end

    // zero bus forces a zero duty
    always_ff @(posedge aclk) begin
        if (en) duty <= (bus_mid_reg == 16'd0) ? 8'd0 : {q_hi_reg, q_lo};
    end
endmodule

[rtl/core/foc_voltage_modulator_top.sv]
// foc voltage modulator: quadrature command and rotor angle in, three duties out.
// s_ channel: one item per voltage_cmd / rotor_angle pair; m_ channel: duties.
// cfg channel writes one register (index, data); the user must do so only while
// the block is idle, which the block itself does not enforce. seven register
// stages (angle multiply, sine lookup, rotation multiply, phase sum, duty scale,
// two duty divide stages); one item per cycle sustained unless the output stage
// is full and m_axis_tready is low.
// when m_axis_tready is low and the output stage holds an item every stage
// holds, and s_axis_tready is low in that same cycle.
// reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults: bus 0, pole pairs 7, others 0.
module foc_voltage_modulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // voltage_cmd [15:0], rotor_angle [31:16]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // duty_a [7:0], duty_b [15:8], duty_c [23:16]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import focvm_pkg::*;

    localparam int NST = 7;

    cfg_t cfg_reg;
    logic [NST-1:0] vld_reg;

    // global stall: pipeline moves unless the output is full and blocked
    logic move;
    assign move = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = move;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = vld_reg[NST-1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{bus_voltage: 16'd0, pole_pairs: 6'd7, reverse_direction: 1'b0,
                         zero_offset: 16'd0, park_mode: 1'b0};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BUS_VOLTAGE: cfg_reg.bus_voltage <= cfg_data;
                REG_POLE_PAIRS:  cfg_reg.pole_pairs <= cfg_data[5:0];
                REG_REVERSE_DIR: cfg_reg.reverse_direction <= cfg_data[0];
                REG_ZERO_OFFSET: cfg_reg.zero_offset <= cfg_data;
                REG_PARK_MODE:   cfg_reg.park_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (move) vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // constant sine table over the quantized angle steps
    logic signed [17:0] sine_tab [SINE_TABLE_DEPTH];
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        assign sine_tab[g] = sine_entry(K_BITS'(g));
    end

    // stage 1: angle product
    logic [21:0] e1_reg;
    logic signed [15:0] cmd1_reg;
    always_ff @(posedge aclk) begin
        if (move) begin
            e1_reg <= 22'(s_axis_tdata[31:16]) * 22'(cfg_reg.pole_pairs);
            cmd1_reg <= $signed(s_axis_tdata[15:0]);
        end
    end

    // stage 2: electrical angle, sine and cosine lookup, command clamp
    logic [15:0] e2;
    logic [K_BITS-1:0] k2;
    logic [K_BITS-1:0] kc2;
    logic signed [17:0] s2_reg, c2_reg;
    logic signed [17:0] uq2_2_reg;
    logic signed [17:0] uq_raw, vb_s;
    always_comb begin
        e2 = cfg_reg.reverse_direction ? 16'(-e1_reg[15:0]) : e1_reg[15:0];
        e2 = e2 - cfg_reg.zero_offset;
        k2 = e2[ANGLE_BITS-1 -: K_BITS];
        kc2 = k2 + K_BITS'(SINE_TABLE_DEPTH / 4);
        uq_raw = 18'(cmd1_reg) * 18'sd2;
        vb_s = $signed({2'b00, cfg_reg.bus_voltage});
    end
    always_ff @(posedge aclk) begin
        if (move) begin
            s2_reg <= sine_tab[k2];
            c2_reg <= sine_tab[kc2];
            if (uq_raw > vb_s) uq2_2_reg <= vb_s;
            else if (uq_raw < -vb_s) uq2_2_reg <= -vb_s;
            else uq2_2_reg <= uq_raw;
        end
    end

    // stage 3: rotation products uq*sa and uq*sb
    logic signed [17:0] sa3, sb3;
    logic signed [35:0] pa3_reg, pb3_reg;
    always_comb begin
        sa3 = cfg_reg.park_mode ? c2_reg : -s2_reg;
        sb3 = cfg_reg.park_mode ? s2_reg : c2_reg;
    end
    always_ff @(posedge aclk) begin
        if (move) begin
            pa3_reg <= uq2_2_reg * sa3;
            pb3_reg <= uq2_2_reg * sb3;
        end
    end

    // stage 4: scale to 2^32 and form the three phase voltages
    logic signed [50:0] a4, kb4, h4;
    logic signed [50:0] va_reg, vb4_reg, vc_reg;
    always_ff @(posedge aclk) begin
        if (move) begin
            va_reg <= a4 + h4;
            vb4_reg <= -(a4 / 2) + kb4 + h4;
            vc_reg <= -(a4 / 2) - kb4 + h4;
        end
    end
    always_comb begin
        a4 = 51'(pa3_reg) <<< 16;
        kb4 = 51'(pb3_reg) * 51'(SQRT3_HALF_Q16);
        h4 = $signed({3'b000, cfg_reg.bus_voltage, 32'd0});
    end

    // stages 5 to 7: clamp, scale and divide per phase
    logic [7:0] da, db, dc;
    focvm_duty u_da (.aclk(aclk), .en(move), .phase_v(va_reg),
                     .bus(cfg_reg.bus_voltage), .duty(da));
    focvm_duty u_db (.aclk(aclk), .en(move), .phase_v(vb4_reg),
                     .bus(cfg_reg.bus_voltage), .duty(db));
    focvm_duty u_dc (.aclk(aclk), .en(move), .phase_v(vc_reg),
                     .bus(cfg_reg.bus_voltage), .duty(dc));

    assign m_axis_tdata = {dc, db, da};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && cfg_reg.bus_voltage == 16'd0 |-> m_axis_tdata == 24'd0)
        else $error("nonzero duty at zero bus");
`endif
endmodule
